@@ rtl/core/rpt_pkg.sv @@
// Shared types, codes and helpers for the relay pulse timer.
package rpt_pkg;

  // Default width of the internal time base
  localparam int unsigned TIME_BITS_DEF = 32;

  // Width of the ms time field and of the timing config registers
  localparam int unsigned MS_W = 32;

  // Request codes
  typedef enum logic [2:0] {
    REQ_TICK       = 3'd0,
    REQ_ACTIVATE   = 3'd1,
    REQ_DEACTIVATE = 3'd2,
    REQ_HOLD       = 3'd3,
    REQ_LOCKOUT    = 3'd4,
    REQ_RELEASE    = 3'd5,
    REQ_RESTART    = 3'd6
  } req_t;

  // Operation state codes as seen on the result channel
  typedef enum logic [1:0] {
    OP_ACTIVE       = 2'd0,
    OP_ACTIVATING   = 2'd1,
    OP_INACTIVE     = 2'd2,
    OP_DEACTIVATING = 2'd3
  } op_code_t;

  // Internal phase state machine, one-hot
  typedef enum logic [3:0] {
    PH_ACTIVE       = 4'b0001,
    PH_ACTIVATING   = 4'b0010,
    PH_INACTIVE     = 4'b0100,
    PH_DEACTIVATING = 4'b1000
  } phase_t;

  // Override modes
  typedef enum logic [1:0] {
    OV_NORMAL  = 2'd0,
    OV_HOLDING = 2'd1,
    OV_LOCKED  = 2'd2
  } ov_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_ACTIVE_LEVEL = 2'd0,
    CFG_ON_TIME      = 2'd1,
    CFG_SETTLE_TIME  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [MS_W-1:0] now_ms;
    logic            report_change;
  } in_item_t;

  typedef struct packed {
    logic       drive;
    logic [1:0] op_state;
    logic [1:0] override_state;
    logic       notify;
    logic [1:0] reported_state;
    logic [1:0] reported_override;
    logic       acted;
  } out_item_t;

  // Live configuration handed to the datapath
  typedef struct packed {
    logic            active_level;
    logic [MS_W-1:0] on_time;
    logic [MS_W-1:0] settle_time;
  } cfg_t;

  // One-hot phase to external code
  function automatic logic [1:0] phase_code(input phase_t ph);
    logic [1:0] code;
    case (ph)
      PH_ACTIVE:       code = OP_ACTIVE;
      PH_ACTIVATING:   code = OP_ACTIVATING;
      PH_DEACTIVATING: code = OP_DEACTIVATING;
      default:         code = OP_INACTIVE;
    endcase
    return code;
  endfunction

endpackage

@@ rtl/core/rpt_cfg_regs.sv @@
// Configuration register bank of the relay pulse timer.
module rpt_cfg_regs
  import rpt_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [MS_W-1:0] cfg_wdata,
  output cfg_t            cfg
);

  logic            active_level_r;
  logic [MS_W-1:0] on_time_r;
  logic [MS_W-1:0] settle_time_r;

  // Writes must land only while idle (the user's duty; the block does not enforce it); the port never stalls
  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_level_r <= 1'b1;
      on_time_r      <= '0;
      settle_time_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_LEVEL: active_level_r <= cfg_wdata[0];
        CFG_ON_TIME:      on_time_r      <= cfg_wdata;
        CFG_SETTLE_TIME:  settle_time_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.active_level = active_level_r;
  assign cfg.on_time      = on_time_r;
  assign cfg.settle_time  = settle_time_r;

endmodule

@@ rtl/core/rpt_core.sv @@
// Relay state registers and the per-request update logic.
module rpt_core
  import rpt_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      load,
  input  in_item_t  item,
  output out_item_t res
);

  localparam int unsigned WIDE_W = TIME_BITS + MS_W;

  phase_t               phase_r,  phase_nxt;
  ov_t                  ov_r,     ov_nxt;
  logic [TIME_BITS-1:0] start_r,  start_nxt;
  logic                 drive_r,  drive_nxt;

  logic [WIDE_W-1:0]    now_wide;
  logic [TIME_BITS-1:0] now_t;
  logic [TIME_BITS-1:0] elapsed;
  logic                 past_delay;
  logic                 past_act;
  logic                 has_delay;
  phase_t               ph_on, ph_off;

  // Time base: truncate or zero-extend the request time
  assign now_wide   = WIDE_W'(item.now_ms);
  assign now_t      = now_wide[TIME_BITS-1:0];
  assign elapsed    = now_t - start_r;
  assign past_delay = WIDE_W'(elapsed) > WIDE_W'(cfg.settle_time);
  assign past_act   = WIDE_W'(elapsed) > WIDE_W'(cfg.on_time);
  assign has_delay  = (cfg.settle_time != '0);
  assign ph_on      = has_delay ? PH_ACTIVATING : PH_ACTIVE;
  assign ph_off     = has_delay ? PH_DEACTIVATING : PH_INACTIVE;

  // Request decode and state update
  always_comb begin
    phase_nxt = phase_r;
    ov_nxt    = ov_r;
    start_nxt = start_r;
    drive_nxt = drive_r;
    res       = '0;
    case (item.req_type)
      REQ_TICK: begin
        if (phase_r == PH_ACTIVATING || phase_r == PH_DEACTIVATING) begin
          if (past_delay) begin
            phase_nxt = (phase_r == PH_ACTIVATING) ? PH_ACTIVE : PH_INACTIVE;
          end
        end else if (phase_r == PH_ACTIVE) begin
          // automatic switch-off after the on time
          if (ov_r == OV_NORMAL && cfg.on_time != '0 && past_act) begin
            drive_nxt             = ~cfg.active_level;
            start_nxt             = now_t;
            phase_nxt             = ph_off;
            res.notify            = 1'b1;
            res.reported_state    = phase_code(ph_off);
            res.reported_override = OV_NORMAL;
            res.acted             = 1'b1;
          end
        end
      end
      REQ_ACTIVATE, REQ_DEACTIVATE: begin
        if (ov_r == OV_NORMAL) begin
          start_nxt = now_t;
          if (item.req_type == REQ_ACTIVATE) begin
            drive_nxt = cfg.active_level;
            phase_nxt = ph_on;
          end else begin
            drive_nxt = ~cfg.active_level;
            phase_nxt = ph_off;
          end
          if (item.report_change) begin
            res.notify            = 1'b1;
            res.reported_state    = phase_code(phase_nxt);
            res.reported_override = OV_NORMAL;
          end
        end
      end
      REQ_HOLD, REQ_LOCKOUT: begin
        // switch only when not yet overridden, then latch the override
        if (ov_r == OV_NORMAL) begin
          start_nxt = now_t;
          if (item.req_type == REQ_HOLD) begin
            drive_nxt = cfg.active_level;
            phase_nxt = ph_on;
          end else begin
            drive_nxt = ~cfg.active_level;
            phase_nxt = ph_off;
          end
        end
        ov_nxt                = (item.req_type == REQ_HOLD) ? OV_HOLDING : OV_LOCKED;
        res.notify            = 1'b1;
        res.reported_state    = phase_code(phase_nxt);
        res.reported_override = ov_nxt;
      end
      REQ_RELEASE: begin
        if (ov_r != OV_NORMAL) begin
          res.notify            = 1'b1;
          res.reported_state    = phase_code(phase_r);
          res.reported_override = OV_NORMAL;
        end
        ov_nxt = OV_NORMAL;
      end
      REQ_RESTART: begin
        // reporting switch-off, then phase forced inactive
        ov_nxt                = OV_NORMAL;
        drive_nxt             = ~cfg.active_level;
        start_nxt             = now_t;
        res.notify            = 1'b1;
        res.reported_state    = phase_code(ph_off);
        res.reported_override = OV_NORMAL;
        phase_nxt             = PH_INACTIVE;
      end
      default: ;
    endcase
    res.drive          = drive_nxt;
    res.op_state       = phase_code(phase_nxt);
    res.override_state = ov_nxt;
  end

  // State registers advance when a request is retired
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_INACTIVE;
      ov_r    <= OV_NORMAL;
      start_r <= '0;
      drive_r <= 1'b0;
    end else if (load) begin
      phase_r <= phase_nxt;
      ov_r    <= ov_nxt;
      start_r <= start_nxt;
      drive_r <= drive_nxt;
    end
  end

`ifndef SYNTHESIS
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(phase_r))
    else $error("phase register lost its one-hot code");

  a_acted_notifies: assert property (@(posedge clk) disable iff (!rst_n)
    load && res.acted |-> res.notify && res.override_state == OV_NORMAL
      && !res.drive == cfg.active_level)
    else $error("auto switch-off without notification or off level");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    load && (item.req_type == REQ_RELEASE || item.req_type == REQ_RESTART)
      |=> ov_r == OV_NORMAL)
    else $error("override not cleared by release or restart");

  a_quiet_report: assert property (@(posedge clk) disable iff (!rst_n)
    load && !res.notify |-> res.reported_state == '0
      && res.reported_override == '0)
    else $error("report fields set without notification");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(phase_r) && $stable(ov_r) && $stable(drive_r))
    else $error("state moved without a retired request");
`endif

endmodule

@@ rtl/core/relay_pulse_timer.sv @@
// Top level of the relay pulse timer: request and result registers around the core.
//
//   port group | direction | contents
//   in_*       | input     | request: req_type, now_ms, report_change
//   out_*      | output    | result: drive, states, notification, acted
//   cfg_*      | input     | register write: index, 32-bit data
//
// One request per cycle sustained while the result is taken (out_ready); the
// result passes the request register, then the result register, after the
// input accept, and a stalled result delays it.
// All state updates happen in a single pass as the request moves into the
// result register; a stalled result holds the request register.
// Synchronous active-low reset: relay off (inverse of active level), phase
// inactive, override normal. The config port never stalls.
module relay_pulse_timer
  import rpt_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [MS_W-1:0] cfg_wdata
);

  logic      in_vld_r, in_vld_nxt;
  in_item_t  in_item_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_item_r;
  logic      load;
  cfg_t      cfg;
  out_item_t res;

  rpt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rpt_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .load  (load),
    .item  (in_item_r),
    .res   (res)
  );

  // Retire the held request whenever the result slot is free or draining
  assign load     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || load;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (load) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (load) begin
      out_vld_nxt = 1'b1;
    end else if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Control flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (load) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule
